/* src/byte_stream_reassembler_unit_macros.svh */
// assertion helpers shared by the reassembler rtl
`ifndef BYTE_STREAM_REASSEMBLER_UNIT_MACROS_SVH
`define BYTE_STREAM_REASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/bsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;

	localparam int STREAM_W = 48;
	localparam int CAPACITY = 64;
	localparam int MAX_OUT = 64;
	localparam int WIN = (MAX_OUT < CAPACITY) ? MAX_OUT : CAPACITY;
	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PEND_W = $clog2(CAPACITY + 1);
	localparam int SPACE_W = 7;
	localparam int PEND_OUT_W = 7;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLOSE,
		ST_PUT,
		ST_READ
	} bsr_state_t;

	// ring slot of the following stream index; the index wrapping to zero restarts the ring
	function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s,
			input logic at_top);
		logic [SLOT_W-1:0] r;
		if (at_top || s == SLOT_W'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = s + SLOT_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/byte_stream_reassembler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_reassembler_unit_macros.svh"
// Byte stream reassembler. Each input item carries one byte at an absolute 48-bit stream
// index (or only an end mark), together with the free space downstream. A byte at the next
// expected index goes out at once, followed by the run of stored bytes behind it, up to the
// free space; a later byte inside the window is held once in a 64-entry ring store, an earlier
// one is dropped. Every input item yields at least one output item, and the final one carries
// tlast. One shared increment/compare unit walks the presence bits one slot per cycle, and
// the ring memory has a single registered read port: an item that pushes no byte goes
// through a close step and a single put, an in-order byte that releases a run of stored
// bytes first scans the run, then reads and presents each stored byte in turn, and each
// put waits while the output side stalls. s_tready is low while an item is being worked on.
module byte_stream_reassembler_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [47:0] stream_index, [55:48] data_byte, [62:56] out_space, [63] zero
	input  wire logic [bsr_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] byte_valid
	input  wire logic                               s_tuser,
	// ends_stream
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [7:0] out_byte, [8] stream_closed, [15:9] pending_count
	output logic [bsr_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// [0] out_valid
	output logic                                    m_tuser,
	// last_of_run
	output logic                                    m_tlast
);
	import bsr_pkg::*;

	localparam logic [STREAM_W-1:0] INDEX_TOP = '1;

	bsr_state_t state_q, state_d;

	// control state
	logic [CAPACITY-1:0] present_q;
	logic [STREAM_W-1:0] next_index_q;
	logic [SLOT_W-1:0]   next_slot_q;
	logic [PEND_W-1:0]   pending_q;
	logic                end_known_q;
	logic [STREAM_W-1:0] end_index_q;
	logic                closed_q;
	logic                m_tvalid_q;

	// per-item working registers
	logic [7:0]          byte_q;
	logic                take_q;
	logic [SPACE_W-1:0]  space_q;
	logic [SPACE_W-1:0]  run_q;
	logic [SPACE_W-1:0]  cnt_q;
	logic [SLOT_W-1:0]   rd_slot_q;
	logic [STREAM_W-1:0] rd_index_q;
	logic [7:0]          rdata_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                m_tuser_q;
	logic                m_tlast_q;

	logic [7:0] store_mem [CAPACITY];

	// input item fields
	logic [STREAM_W-1:0] in_index;
	logic [7:0]          in_byte;
	logic [SPACE_W-1:0]  in_space;
	logic                in_bv;
	logic                in_ends;

	logic                accept;
	logic [SPACE_W-1:0]  space_sat;
	logic                live;
	logic                at_next;
	logic                take;
	logic [STREAM_W:0]   win_hi;
	logic                in_win;
	logic [STREAM_W-1:0] off;
	logic [SLOT_W:0]     store_sum;
	logic [SLOT_W-1:0]   store_slot;
	logic                store;
	logic [SLOT_W-1:0]   slot_after;
	logic                scan_hit;
	logic                out_free;
	logic                out_load;
	logic                rd_go;
	logic                last_item;
	logic [7:0]          byte_sel;
	logic [PEND_W+PEND_OUT_W-1:0] pend_ext;

	assign in_index = s_tdata[STREAM_W-1:0];
	assign in_byte  = s_tdata[STREAM_W+7:STREAM_W];
	assign in_space = s_tdata[STREAM_W+8+SPACE_W-1:STREAM_W+8];
	assign in_bv    = s_tuser;
	assign in_ends  = s_tlast;

	assign accept    = s_tvalid && s_tready;
	assign space_sat = (in_space > SPACE_W'(WIN)) ? SPACE_W'(WIN) : in_space;
	assign live      = in_bv && !closed_q;
	assign at_next   = (in_index == next_index_q);
	assign take      = live && at_next && (space_sat != '0);

	// window check is done without wrap, like the absolute index compare it stands for
	assign win_hi = {1'b0, next_index_q} + (STREAM_W + 1)'(space_sat);
	assign in_win = live && !at_next && (in_index > next_index_q)
		&& ({1'b0, in_index} < win_hi);

	// offset into the window is below the ring depth, so one conditional subtract wraps it
	assign off        = in_index - next_index_q;
	assign store_sum  = {1'b0, next_slot_q} + {1'b0, off[SLOT_W-1:0]};
	assign store_slot = (store_sum >= (SLOT_W + 1)'(CAPACITY))
		? SLOT_W'(store_sum - (SLOT_W + 1)'(CAPACITY)) : store_sum[SLOT_W-1:0];
	assign store      = in_win && !present_q[store_slot];

	assign slot_after = slot_step(next_slot_q, next_index_q == INDEX_TOP);
	assign scan_hit   = present_q[next_slot_q]
		&& (({1'b0, run_q} + (SPACE_W + 1)'(1)) < {1'b0, space_q});

	assign out_free  = !m_tvalid_q || m_tready;
	assign last_item = (cnt_q == run_q);
	assign byte_sel  = (cnt_q == '0) ? (take_q ? byte_q : 8'h00) : rdata_q;
	assign pend_ext  = {{PEND_OUT_W{1'b0}}, pending_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = take ? ST_SCAN : ST_CLOSE;
				end
			end
			ST_SCAN: begin
				if (!scan_hit) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (out_free) begin
					state_d = last_item ? ST_IDLE : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_PUT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		rd_go    = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_PUT:   out_load = out_free;
			ST_READ:  rd_go = 1'b1;
			default:  s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			present_q    <= '0;
			next_index_q <= '0;
			next_slot_q  <= '0;
			pending_q    <= '0;
			end_known_q  <= 1'b0;
			end_index_q  <= '0;
			closed_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (in_ends) begin
					end_known_q <= 1'b1;
					end_index_q <= in_index + STREAM_W'(in_bv);
				end
				if (take) begin
					// a held copy of the byte at the head is replaced by the live one
					present_q[next_slot_q] <= 1'b0;
					if (present_q[next_slot_q]) begin
						pending_q <= pending_q - PEND_W'(1);
					end
					next_index_q <= next_index_q + STREAM_W'(1);
					next_slot_q  <= slot_after;
				end
				if (store) begin
					present_q[store_slot] <= 1'b1;
					pending_q <= pending_q + PEND_W'(1);
				end
			end
			if (state_q == ST_SCAN && scan_hit) begin
				pending_q    <= pending_q - PEND_W'(1);
				next_index_q <= next_index_q + STREAM_W'(1);
				next_slot_q  <= slot_after;
			end
			if (state_q == ST_CLOSE && end_known_q && next_index_q == end_index_q) begin
				closed_q <= 1'b1;
			end
			if (rd_go) begin
				present_q[rd_slot_q] <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q     <= in_byte;
			take_q     <= take;
			space_q    <= space_sat;
			run_q      <= '0;
			cnt_q      <= '0;
			rd_slot_q  <= slot_after;
			rd_index_q <= next_index_q + STREAM_W'(1);
		end
		if (state_q == ST_SCAN && scan_hit) begin
			run_q <= run_q + SPACE_W'(1);
		end
		if (rd_go) begin
			rd_slot_q  <= slot_step(rd_slot_q, rd_index_q == INDEX_TOP);
			rd_index_q <= rd_index_q + STREAM_W'(1);
			cnt_q      <= cnt_q + SPACE_W'(1);
		end
		if (out_load) begin
			m_tdata_q <= {pend_ext[PEND_OUT_W-1:0], closed_q, byte_sel};
			m_tuser_q <= take_q;
			m_tlast_q <= last_item;
		end
	end

	// ring store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept && store) begin
			store_mem[store_slot] <= in_byte;
		end
		if (rd_go) begin
			rdata_q <= store_mem[rd_slot_q];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`BSR_ASSERT_NOW(a_null_item_is_last, m_tvalid && !m_tuser, m_tlast, "empty item not marked last")
	`BSR_ASSERT_NOW(a_pending_matches, state_q == ST_IDLE, $countones(present_q) == int'(pending_q), "pending count out of step with presence bits")
	`BSR_ASSERT_NEXT(a_closed_sticky, closed_q, closed_q, "closed flag dropped")
	`BSR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while an item is in work")

endmodule
`default_nettype wire
